>>> sv/sequential_list_engine_unit_defines.svh
// Shared assertion macros. Users must have clk and rst_n in scope.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SLE_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sle_pkg.sv
package sle_pkg;

    localparam int CMD_W     = 2;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 7;

    // command codes; the fourth code is a no-op
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] removed_value;
        logic [OUT_CNT_W-1:0]     found_position;
        logic [OUT_CNT_W-1:0]     entry_count;
    } result_t;

endpackage

>>> sv/sle_if.sv
interface sle_req_if;
    import sle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, position, value, input ready);
    modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [OUT_CNT_W-1:0]     found_position;
    logic [OUT_CNT_W-1:0]     entry_count;

    modport source (output valid, ok, removed_value, found_position, entry_count,
                    input ready);
    modport sink   (input valid, ok, removed_value, found_position, entry_count,
                    output ready);
endinterface

>>> sv/sle_mem.sv
module sle_mem #(
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [sle_pkg::DATA_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [sle_pkg::DATA_W-1:0] rdata
);
    import sle_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> sv/sle_ctrl.sv
`include "sequential_list_engine_unit_defines.svh"

module sle_ctrl #(
    parameter int CAPACITY = 64,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sle_req_if.sink                    req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sle_pkg::result_t           res,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_raddr,
    input  logic [sle_pkg::DATA_W-1:0] mem_rdata,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [sle_pkg::DATA_W-1:0] mem_wdata
);
    import sle_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        stop_reg, stop_next;
    logic                 rdv_reg, rdv_next;
    logic [AW-1:0]        rda_reg, rda_next;
    logic                 ok_reg, ok_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [OUT_CNT_W-1:0] found_reg, found_next;

    logic [CMP_W-1:0] pos_c, cnt_c;
    logic             ins_ok, ins_tail, del_ok;
    logic [AW-1:0]    pos_idx, cnt_last;

    assign pos_c    = CMP_W'(req.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign ins_ok   = (pos_c != '0) && (pos_c <= cnt_c + CMP_W'(1))
                      && (count_reg < CNT_W'(CAPACITY));
    assign ins_tail = (pos_c == cnt_c + CMP_W'(1));
    assign del_ok   = (pos_c != '0) && (pos_c <= cnt_c);
    assign pos_idx  = AW'(pos_c - CMP_W'(1));
    assign cnt_last = AW'(count_reg - CNT_W'(1));

    assign req.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.ok             = ok_reg;
        res.removed_value  = rem_reg;
        res.found_position = found_reg;
        res.entry_count    = OUT_CNT_W'(count_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        stop_next  = stop_reg;
        rdv_next   = 1'b0;
        rda_next   = rda_reg;
        ok_next    = ok_reg;
        rem_next   = rem_reg;
        found_next = found_reg;
        mem_re     = 1'b0;
        mem_raddr  = addr_reg;
        mem_we     = 1'b0;
        mem_waddr  = rda_reg;
        mem_wdata  = mem_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    val_next   = req.value;
                    ok_next    = 1'b0;
                    rem_next   = '0;
                    found_next = '0;
                    idx_next   = pos_idx;
                    if (req.cmd == CMD_INSERT && ins_ok)
                    begin
                        stop_next = pos_idx;
                        addr_next = cnt_last;
                        state_next = ins_tail ? S_WRITE : S_READ;
                    end
                    else if (req.cmd == CMD_DELETE && del_ok)
                    begin
                        addr_next  = pos_idx;
                        stop_next  = cnt_last;
                        state_next = S_READ;
                    end
                    else if (req.cmd == CMD_LOCATE && count_reg != '0)
                    begin
                        addr_next  = '0;
                        stop_next  = cnt_last;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                mem_re   = 1'b1;
                rdv_next = 1'b1;
                rda_next = addr_reg;
                if (addr_reg == stop_reg)
                begin
                    state_next = S_DRAIN;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    addr_next = addr_reg - AW'(1);
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    if (cmd_reg == CMD_DELETE)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // write-back stage: data read last cycle from rda_reg
        if (rdv_reg)
        begin
            priority if (cmd_reg == CMD_INSERT)
            begin
                mem_we    = 1'b1;
                mem_waddr = rda_reg + AW'(1);
            end
            else if (cmd_reg == CMD_DELETE)
            begin
                if (rda_reg == idx_reg)
                begin
                    rem_next = mem_rdata;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rda_reg - AW'(1);
                end
            end
            else if (mem_rdata == val_reg)
            begin
                // locate hit: stop the walk, drop the read in flight
                found_next = OUT_CNT_W'(rda_reg) + OUT_CNT_W'(1);
                ok_next    = 1'b1;
                rdv_next   = 1'b0;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        addr_reg  <= addr_next;
        stop_reg  <= stop_next;
        rda_reg   <= rda_next;
        ok_reg    <= ok_next;
        rem_reg   <= rem_next;
        found_reg <= found_next;
    end

    `SLE_ASSERT(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SLE_ASSERT(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr, "read and write same entry")
    `SLE_ASSERT(a_rdv_walk, rdv_reg, state_reg == S_READ || state_reg == S_DRAIN, "stray read data")
    `SLE_ASSERT_NEXT(a_done_idle, res_valid && res_ready, state_reg == S_IDLE, "no return to idle")
endmodule

>>> sv/sequential_list_engine_unit.sv
// Sequential list engine: a packed list of signed 32-bit elements in one
// single-port-write / single-port-read synchronous RAM, CAPACITY deep.
// req channel: valid/ready transaction carrying cmd, position, value.
//   insert at a 1-based position, delete at a 1-based position, or locate
//   the first position holding a value. A code of 3 is a no-op.
// rsp channel: valid/ready transaction carrying ok, removed_value,
//   found_position and entry_count; exactly one per request, in order.
// Sequencing: the sequencer walks the shifted or searched entries one
//   per cycle through the RAM read port and writes each shifted entry
//   back in the following cycle. An insert at the tail writes without a
//   walk; failed and no-op commands go straight to the response.
// Throughput: one transaction in flight at a time; req.ready is high only
//   while the sequencer is idle.
// Output: a result register holds the response, so the next request is
//   taken while the previous response waits. If rsp stays stalled, the
//   next finished result waits in the sequencer and req.ready stays low.
// Reset: the list count clears to zero and the list is empty at once;
//   RAM contents are not cleared (only entries below the count are read).
module sequential_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    sle_req_if.sink    req,
    sle_rsp_if.source  rsp
);
    import sle_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // sequencer <-> RAM
    logic              mem_re, mem_we;
    logic [AW-1:0]     mem_raddr, mem_waddr;
    logic [DATA_W-1:0] mem_rdata, mem_wdata;

    // sequencer -> result register
    logic    res_valid, res_ready;
    result_t res;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    load;

    sle_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    sle_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_data_next  = load ? res : out_data_reg;
        out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_data_reg.ok;
    assign rsp.removed_value  = out_data_reg.removed_value;
    assign rsp.found_position = out_data_reg.found_position;
    assign rsp.entry_count    = out_data_reg.entry_count;
endmodule
